[hdl/second_order_pdm_modulator_defines.svh]
// assertion macros for the second-order pdm modulator checker
// no dependencies; taken in by the checker file only
`ifndef SECOND_ORDER_PDM_MODULATOR_DEFINES_SVH
`define SECOND_ORDER_PDM_MODULATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SOPDM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pdm modulator check failed");

// consequent checked in the cycle after the antecedent
`define SOPDM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pdm modulator check failed");

`endif

[hdl/sopdm_pkg.sv]
// shared types, constants and helpers of the second-order pdm modulator
// no dependencies; used by every other file of the block but the defines header
package sopdm_pkg;

  localparam int unsigned OsrMax      = 32;
  localparam int unsigned OsrCapHw    = 32;
  localparam int unsigned OsrLimit    = (OsrMax < OsrCapHw) ? OsrMax : OsrCapHw;
  localparam int unsigned OsrW        = 6;
  localparam int unsigned StepW       = $clog2(2 * OsrLimit + 1);
  localparam int unsigned SampleW     = 16;
  localparam int unsigned AddW        = SampleW + 2;
  localparam int unsigned IntW        = 32;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CntW        = $clog2(ByteW);
  localparam logic [OsrW-1:0] OsrReset = OsrW'(16);

  // feedback seen from the integrators: bit 1 subtracts +32767, bit 0 subtracts -32768
  localparam logic [IntW-1:0] FbTermOne  = IntW'(-32'sd32767);
  localparam logic [IntW-1:0] FbTermZero = IntW'(32'sd32768);

  typedef enum logic [1:0] {
    ALU_ACC2,
    ALU_ACC1,
    ALU_FB2
  } alu_op_e;

  typedef struct packed {
    alu_op_e                     op;
    logic                        fb_bit;
    logic signed [SampleW-1:0]   sample;
  } alu_req_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
  } byte_beat_t;

  // number of modulator steps per sample, ratio clamped to 1..limit
  function automatic logic [StepW-1:0] eff_steps(input logic [OsrW-1:0] osr);
    logic [OsrW-1:0] r;
    r = osr;
    if (r == '0) r = OsrW'(1);
    if (r > OsrW'(OsrLimit)) r = OsrW'(OsrLimit);
    return StepW'({r, 1'b0});
  endfunction

endpackage

[hdl/sopdm_if.sv]
// channel interfaces of the second-order pdm modulator: sample in, byte out, config
// depends on sopdm_pkg for field widths
interface sopdm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sopdm_pkg::SampleW-1:0] pcm_sample;
  logic                                 silent;
  modport source (output valid, output pcm_sample, output silent, input ready);
  modport sink   (input valid, input pcm_sample, input silent, output ready);
endinterface

interface sopdm_out_if;
  logic                          valid;
  logic                          ready;
  logic [sopdm_pkg::ByteW-1:0]   pdm_byte;
  logic                          last;
  modport source (output valid, output pdm_byte, output last, input ready);
  modport sink   (input valid, input pdm_byte, input last, output ready);
endinterface

interface sopdm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sopdm_pkg::OsrW-1:0]   osr;
  modport source (output valid, output osr, input ready);
  modport sink   (input valid, input osr, output ready);
endinterface

[hdl/sopdm_alu.sv]
// shared 32-bit adder of the modulator, with its operand selection
// depends on sopdm_pkg
module sopdm_alu (
  input  sopdm_pkg::alu_req_t         req_i,
  input  logic [sopdm_pkg::IntW-1:0]  s1_i,
  input  logic [sopdm_pkg::IntW-1:0]  s2_i,
  output logic [sopdm_pkg::IntW-1:0]  sum_o
);

  logic [sopdm_pkg::IntW-1:0] fb_term;
  logic [sopdm_pkg::AddW-1:0] addend;
  logic [sopdm_pkg::IntW-1:0] op_a;
  logic [sopdm_pkg::IntW-1:0] op_b;

  assign fb_term = req_i.fb_bit ? sopdm_pkg::FbTermOne : sopdm_pkg::FbTermZero;

  // sample minus feedback, narrow enough to stay off the wide path
  assign addend = {{2{req_i.sample[sopdm_pkg::SampleW-1]}}, req_i.sample}
                + fb_term[sopdm_pkg::AddW-1:0];

  always_comb begin
    op_a = s2_i;
    op_b = fb_term;
    unique case (req_i.op)
      sopdm_pkg::ALU_ACC2: begin
        op_a = s2_i;
        op_b = s1_i;
      end
      sopdm_pkg::ALU_ACC1: begin
        op_a = s1_i;
        op_b = {{(sopdm_pkg::IntW - sopdm_pkg::AddW){addend[sopdm_pkg::AddW-1]}}, addend};
      end
      sopdm_pkg::ALU_FB2: begin
        op_a = s2_i;
        op_b = fb_term;
      end
      default: begin
        op_a = s2_i;
        op_b = fb_term;
      end
    endcase
  end

  assign sum_o = op_a + op_b;

endmodule

[hdl/sopdm_seq.sv]
// step sequencer: integrators, bit packing and the three-phase step over the shared adder
// depends on sopdm_pkg and sopdm_alu
module sopdm_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [sopdm_pkg::SampleW-1:0] pcm_sample_i,
  input  logic                                 silent_i,
  input  logic [sopdm_pkg::OsrW-1:0]           osr_i,
  input  logic                                 slot_free_i,
  output sopdm_pkg::byte_beat_t                beat_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StAcc2 = 2'd1;
  localparam logic [1:0] StAcc1 = 2'd2;
  localparam logic [1:0] StFb2  = 2'd3;

  logic [1:0]                          state_q, state_d;
  logic [sopdm_pkg::IntW-1:0]          s1_q, s1_d;
  logic [sopdm_pkg::IntW-1:0]          s2_q, s2_d;
  logic [sopdm_pkg::ByteW-1:0]         byte_q, byte_d;
  logic [sopdm_pkg::CntW-1:0]          cnt_q, cnt_d;
  logic [sopdm_pkg::StepW-1:0]         steps_q, steps_d;
  logic signed [sopdm_pkg::SampleW-1:0] sample_q, sample_d;
  logic                                silent_q, silent_d;
  logic                                fb_bit_q, fb_bit_d;

  sopdm_pkg::alu_req_t        alu_req;
  logic [sopdm_pkg::IntW-1:0] sum;
  logic [sopdm_pkg::ByteW-1:0] new_byte;
  logic                       byte_done;
  logic                       stall;
  logic                       accept;

  sopdm_alu u_alu (
    .req_i (alu_req),
    .s1_i  (s1_q),
    .s2_i  (s2_q),
    .sum_o (sum)
  );

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign new_byte  = {byte_q[sopdm_pkg::ByteW-2:0], fb_bit_q};
  assign byte_done = !silent_q && (cnt_q == sopdm_pkg::CntW'(sopdm_pkg::ByteW - 1));
  assign stall     = byte_done && !slot_free_i;

  always_comb begin
    alu_req.fb_bit = fb_bit_q;
    alu_req.sample = sample_q;
    unique case (state_q)
      StAcc2:  alu_req.op = sopdm_pkg::ALU_ACC2;
      StAcc1:  alu_req.op = sopdm_pkg::ALU_ACC1;
      default: alu_req.op = sopdm_pkg::ALU_FB2;
    endcase
  end

  // a byte leaves on the final phase of its eighth step; last when fewer than 8 steps remain
  assign beat_o.valid = (state_q == StFb2) && byte_done && slot_free_i;
  assign beat_o.data  = new_byte;
  assign beat_o.last  = (steps_q <= sopdm_pkg::StepW'(sopdm_pkg::ByteW));

  always_comb begin
    state_d  = state_q;
    s1_d     = s1_q;
    s2_d     = s2_q;
    byte_d   = byte_q;
    cnt_d    = cnt_q;
    steps_d  = steps_q;
    sample_d = sample_q;
    silent_d = silent_q;
    fb_bit_d = fb_bit_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          steps_d  = sopdm_pkg::eff_steps(osr_i);
          sample_d = silent_i ? '0 : pcm_sample_i;
          silent_d = silent_i;
          state_d  = StAcc2;
        end
      end
      StAcc2: begin
        s2_d     = sum;
        // feedback is negative only for a strictly positive second integrator
        fb_bit_d = !((sum != '0) && !sum[sopdm_pkg::IntW-1]);
        state_d  = StAcc1;
      end
      StAcc1: begin
        s1_d    = sum;
        state_d = StFb2;
      end
      StFb2: begin
        if (!stall) begin
          s2_d = sum;
          if (!silent_q) begin
            byte_d = byte_done ? '0 : new_byte;
            cnt_d  = cnt_q + 1'b1;
          end
          steps_d = steps_q - 1'b1;
          state_d = (steps_q == sopdm_pkg::StepW'(1)) ? StIdle : StAcc2;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      s1_q    <= '0;
      s2_q    <= '0;
      byte_q  <= '0;
      cnt_q   <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      byte_q  <= byte_d;
      cnt_q   <= cnt_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    silent_q <= silent_d;
    fb_bit_q <= fb_bit_d;
  end

endmodule

[hdl/sopdm_obuf.sv]
// output register holding one finished byte until the receiver takes it
// depends on sopdm_pkg
module sopdm_obuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sopdm_pkg::byte_beat_t         beat_i,
  output logic                          slot_free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sopdm_pkg::ByteW-1:0]   pdm_byte_o,
  output logic                          last_o
);

  logic                        valid_q, valid_d;
  logic [sopdm_pkg::ByteW-1:0] data_q;
  logic                        last_q;

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (beat_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.valid) begin
      data_q <= beat_i.data;
      last_q <= beat_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign pdm_byte_o  = data_q;
  assign last_o      = last_q;

endmodule

[hdl/second_order_pdm_modulator.sv]
// second-order delta-sigma modulator turning pcm samples into packed pdm bytes
// depends on sopdm_pkg, sopdm_if, sopdm_seq and sopdm_obuf
//
// in_i takes one beat per sample: a signed 16-bit pcm_sample and a silent flag.
// out_o gives packed pdm bytes, earliest bit in bit 7, last set on the final
// byte that a sample completes. cfg_i writes the oversampling ratio osr
// (reset 16, 0 acts as 1, values above 32 act as 32); write it only while idle.
// each sample runs 2*osr modulator steps; every step uses the single shared
// 32-bit adder in turn for the second integrator, the first integrator and the
// feedback, so in_i drops ready after a beat and takes no new sample until the
// last step of the current one is done. a byte is registered into out_o at the
// end of the step that completes it, the one that adds the last bit the partial
// byte still lacked. silent samples advance the integrators on zero input and
// give no bytes.
// the output register holds one byte; while it is full and not taken, the
// sequencer waits at the step that completes the next byte, so no byte is lost
// and every stalled cycle adds to the sample's time.
// reset clears both integrators and the partial byte and sets the ratio to 16.
module second_order_pdm_modulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  sopdm_in_if.sink           in_i,
  sopdm_out_if.source        out_o,
  sopdm_cfg_if.sink          cfg_i
);

  logic [sopdm_pkg::OsrW-1:0] osr_q;
  logic                       slot_free;
  sopdm_pkg::byte_beat_t      beat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osr_q <= sopdm_pkg::OsrReset;
    end else if (cfg_i.valid) begin
      osr_q <= cfg_i.osr;
    end
  end

  sopdm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .pcm_sample_i (in_i.pcm_sample),
    .silent_i     (in_i.silent),
    .osr_i        (osr_q),
    .slot_free_i  (slot_free),
    .beat_o       (beat)
  );

  sopdm_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .slot_free_o (slot_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .pdm_byte_o  (out_o.pdm_byte),
    .last_o      (out_o.last)
  );

endmodule

[hdl/sopdm_checker.sv]
// port-level checks of the second-order pdm modulator, bound to the top level
// depends on sopdm_pkg and second_order_pdm_modulator_defines.svh
`include "second_order_pdm_modulator_defines.svh"

module sopdm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [sopdm_pkg::ByteW-1:0]   pdm_byte_i,
  input logic                          last_i
);

  // a stalled output beat keeps its byte
  `SOPDM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(pdm_byte_i) && $stable(last_i))

  // a sample keeps the block busy for at least its first step
  `SOPDM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // new bytes only come out of a sample at work
  `SOPDM_ASSERT_NOW(a_byte_from_work, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i))

endmodule

bind second_order_pdm_modulator sopdm_checker u_sopdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pdm_byte_i  (out_o.pdm_byte),
  .last_i      (out_o.last)
);

[tb/sv/pdm_byte_checker.sv]
`timescale 1ns / 1ps
// checker for the second-order pdm modulator: watches the sample, byte and ratio channels,
// predicts every packed pdm byte and compares it beat by beat
// depends on sopdm_pkg and sopdm_if; instantiated beside the block by the testbench top
module pdm_byte_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sopdm_in_if         sample_i,
  sopdm_out_if        byte_i,
  sopdm_cfg_if        cfg_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  localparam logic [sopdm_pkg::OsrW-1:0] RatioReset  = 6'd16;
  localparam int unsigned                RatioCap    = 32;
  localparam logic [sopdm_pkg::IntW-1:0] FbNegMag    = 32'd32768;
  localparam logic [sopdm_pkg::IntW-1:0] FbPos       = 32'd32767;

  typedef struct packed {
    logic [sopdm_pkg::ByteW-1:0] pdm_byte;
    logic                        last;
  } pdm_beat_t;

  pdm_beat_t                   expected_bytes[$];
  logic [sopdm_pkg::OsrW-1:0]  ratio;
  logic [sopdm_pkg::IntW-1:0]  integ1;
  logic [sopdm_pkg::IntW-1:0]  integ2;
  logic [sopdm_pkg::ByteW-1:0] shift_byte;
  int unsigned                 bit_count;

  initial fail_count_o = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: pdm mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic int unsigned steps_per_sample(input logic [sopdm_pkg::OsrW-1:0] r);
    int unsigned eff;
    eff = (r == '0) ? 1 : int'(r);
    if (eff > RatioCap) eff = RatioCap;
    return 2 * eff;
  endfunction

  // one modulator step, integrators wrap at 32 bits; returns the pdm bit
  function automatic logic modulator_step(input logic [sopdm_pkg::IntW-1:0] drive);
    integ2 = integ2 + integ1;
    if (integ2 != '0 && !integ2[sopdm_pkg::IntW-1]) begin
      integ1 = integ1 + drive + FbNegMag;
      integ2 = integ2 + FbNegMag;
      return 1'b0;
    end
    integ1 = integ1 + drive - FbPos;
    integ2 = integ2 - FbPos;
    return 1'b1;
  endfunction

  task automatic predict_pdm_bytes(input logic [sopdm_pkg::SampleW-1:0] pcm,
                                   input logic silent);
    logic [sopdm_pkg::IntW-1:0] drive;
    logic                       bit_out;
    logic                       held_valid;
    pdm_beat_t                  held;
    int unsigned                steps;
    drive      = silent ? '0 : {{(sopdm_pkg::IntW-sopdm_pkg::SampleW){
                                  pcm[sopdm_pkg::SampleW-1]}}, pcm};
    steps      = steps_per_sample(ratio);
    held_valid = 1'b0;
    held       = '0;
    for (int unsigned i = 0; i < steps; i++) begin
      bit_out = modulator_step(drive);
      // warm-up samples move the integrators only
      if (!silent) begin
        shift_byte = {shift_byte[sopdm_pkg::ByteW-2:0], bit_out};
        bit_count++;
        if (bit_count == sopdm_pkg::ByteW) begin
          if (held_valid) expected_bytes.push_back(held);
          held       = '{pdm_byte: shift_byte, last: 1'b0};
          held_valid = 1'b1;
          shift_byte = '0;
          bit_count  = 0;
        end
      end
    end
    if (held_valid) begin
      held.last = 1'b1;
      expected_bytes.push_back(held);
    end
  endtask

  task automatic check_pdm_byte(input logic [sopdm_pkg::ByteW-1:0] got_byte,
                                input logic got_last);
    pdm_beat_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("byte %02h (last %0b) with none expected", got_byte, got_last));
      return;
    end
    want = expected_bytes.pop_front();
    if (got_byte !== want.pdm_byte)
      report_mismatch($sformatf("pdm_byte %02h, expected %02h", got_byte, want.pdm_byte));
    if (got_last !== want.last)
      report_mismatch($sformatf("last %0b on byte %02h, expected %0b", got_last, got_byte,
                                want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio      = RatioReset;
      integ1     = '0;
      integ2     = '0;
      shift_byte = '0;
      bit_count  = 0;
      expected_bytes.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) ratio = cfg_i.osr;
      if (sample_i.valid && sample_i.ready)
        predict_pdm_bytes(sample_i.pcm_sample, sample_i.silent);
      if (byte_i.valid && byte_i.ready) check_pdm_byte(byte_i.pdm_byte, byte_i.last);
      outstanding_o <= expected_bytes.size();
    end
  end

endmodule

[tb/sv/tb_second_order_pdm_modulator.sv]
`timescale 1ns / 1ps
// testbench top for the second-order pdm modulator: drives samples and ratio writes,
// randomises gaps and back-pressure, and gives the verdict
// depends on sopdm_pkg, sopdm_if, second_order_pdm_modulator and pdm_byte_checker
module tb_second_order_pdm_modulator;

  localparam int unsigned SettleCycles   = 250;
  localparam int unsigned StallLimit     = 5000;
  localparam int unsigned RandomSegments = 12;
  localparam int unsigned SegmentItems   = 21;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  sopdm_in_if  sample_ch ();
  sopdm_out_if byte_ch ();
  sopdm_cfg_if cfg_ch ();

  second_order_pdm_modulator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_ch),
    .out_o  (byte_ch),
    .cfg_i  (cfg_ch)
  );

  pdm_byte_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_i      (sample_ch),
    .byte_i        (byte_ch),
    .cfg_i         (cfg_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    byte_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles without any beat on any channel
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // valid is left high after the beat so that back-to-back samples need one assignment
  task automatic push_sample(input logic [sopdm_pkg::SampleW-1:0] pcm, input logic silent);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.pcm_sample <= pcm;
    sample_ch.silent     <= silent;
    do @(posedge clk_i); while (!sample_ch.ready);
  endtask

  // hold off until every byte is out, then let a silent or part-byte sample finish
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_ratio(input logic [sopdm_pkg::OsrW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.osr   <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [sopdm_pkg::OsrW-1:0] pick_ratio();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return sopdm_pkg::OsrW'(32);
      3, 4:    return sopdm_pkg::OsrW'($urandom);
      default: return sopdm_pkg::OsrW'($urandom_range(8, 1));
    endcase
  endfunction

  initial begin
    logic [sopdm_pkg::SampleW-1:0] burst_value;
    int unsigned                   burst_left;
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    sample_ch.valid      = 1'b0;
    sample_ch.pcm_sample = '0;
    sample_ch.silent     = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.osr           = '0;
    byte_ch.ready        = 1'b0;
    quiet_cycles         = 0;
    burst_left           = 0;
    burst_value          = '0;
    send_idle_pct        = 30;
    recv_idle_pct        = 85;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ratio: warm-up with non-zero silent samples, then the field extremes
    push_sample(16'h7FFF, 1'b1);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h5555, 1'b0);
    push_sample(16'hAAAA, 1'b0);
    // zero ratio acts as one: most samples complete no byte
    wait_idle();
    write_ratio('0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h1234, 1'b0);
    push_sample(16'h4000, 1'b1);
    push_sample(16'hC000, 1'b0);
    push_sample(16'h0000, 1'b0);
    // ratios above the cap, then the cap itself and a ratio of one
    wait_idle();
    write_ratio('1);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    wait_idle();
    write_ratio(sopdm_pkg::OsrW'(33));
    push_sample(16'h4321, 1'b0);
    wait_idle();
    write_ratio(sopdm_pkg::OsrW'(32));
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0000, 1'b1);
    wait_idle();
    write_ratio(sopdm_pkg::OsrW'(1));
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h7FFF, 1'b0);

    for (int seg = 0; seg < RandomSegments; seg++) begin
      if (seg == RandomSegments / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 30;
      end
      if (seg == 2 * RandomSegments / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      write_ratio(pick_ratio());
      for (int n = 0; n < SegmentItems; n++) begin
        // runs near full scale push the loop into overload and the integrators towards wrap
        if (burst_left == 0 && $urandom_range(99) < 12) begin
          burst_left  = $urandom_range(24, 6);
          burst_value = $urandom_range(1)
                        ? sopdm_pkg::SampleW'(16'h7FFF - $urandom_range(64))
                        : sopdm_pkg::SampleW'(16'h8000 + $urandom_range(64));
        end
        if (burst_left != 0) begin
          burst_left--;
          push_sample(burst_value, 1'b0);
        end else begin
          case ($urandom_range(9))
            0:       push_sample(sopdm_pkg::SampleW'($urandom), 1'b1);
            1, 2:    push_sample(sopdm_pkg::SampleW'($urandom_range(512) - 256), 1'b0);
            default: push_sample(sopdm_pkg::SampleW'($urandom), 1'b0);
          endcase
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
